FILE: rtl/lfpd_pkg.sv
package lfpd_pkg;

  localparam logic [7:0] HeaderByte = 8'h69;
  localparam logic [7:0] TrailCr = 8'h0D;
  localparam logic [7:0] TrailLf = 8'h0A;

  typedef enum logic [1:0] {
    KindFrame = 2'd0,
    KindBad   = 2'd1,
    KindRead  = 2'd2
  } kind_e;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic [8:0] read_addr;
  } cmd_t;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] dest;
    logic [7:0] board_type;
    logic [7:0] frame_id;
    logic [7:0] func_code;
    logic [7:0] payload_len;
    logic [7:0] lin_channel;
    logic [8:0] frame_start;
    logic [7:0] bad_count;
    logic       ack;
    logic [7:0] read_data;
    logic       last;
  } res_t;

  function automatic logic [2:0] class_of(logic [7:0] bt);
    logic [2:0] c;
    unique case (bt)
      8'h01: c = 3'd0;
      8'h02: c = 3'd1;
      8'h03: c = 3'd2;
      8'h04: c = 3'd3;
      8'h05, 8'h07: c = 3'd4;
      default: c = 3'd5;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/length_framed_packet_deframer_unit.sv
// Length framed packet deframer. Push bytes (op 0) or read ring bytes (op 1)
// through the push/full queue; results appear on the empty/pop queue. After
// each pushed byte the scanner walks the buffered bytes in the 512-entry ring,
// one ring read per SScan/SScanW step; a read goes through SRdWait and SRdOut,
// and a new command is taken only back in SIdle. Each good frame descriptor
// is held back until the next result of the same push or the end of the scan,
// so its last flag is known when it leaves; the final descriptor of a push
// leaves from SBad once the result register is free.
module length_framed_packet_deframer_unit #(
  parameter int RING_DEPTH = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic       op_i,
  input  logic [7:0] rx_byte_i,
  input  logic [8:0] read_addr_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [2:0] dest_o,
  output logic [7:0] board_type_o,
  output logic [7:0] frame_id_o,
  output logic [7:0] func_code_o,
  output logic [7:0] payload_len_o,
  output logic [7:0] lin_channel_o,
  output logic [8:0] frame_start_o,
  output logic [7:0] bad_count_o,
  output logic       ack_o,
  output logic [7:0] read_data_o,
  output logic       last_o
);
  logic ack_en_q;
  lfpd_pkg::cmd_t cmd, q_cmd;
  lfpd_pkg::res_t res;
  logic q_valid, q_take, res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ack_en_q <= 1'b1;
    else if (cfg_we_i) ack_en_q <= cfg_wdata_i;
  end

  assign cmd = '{op: op_i, rx_byte: rx_byte_i, read_addr: read_addr_i};

  lfpd_front u_front (
    .clk_i, .rst_ni, .push, .full, .cmd_i(cmd),
    .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_take_i(q_take)
  );

  lfpd_back #(.RingDepth(RING_DEPTH)) u_back (
    .clk_i, .rst_ni, .ack_en_i(ack_en_q), .q_valid_i(q_valid), .q_cmd_i(q_cmd),
    .q_take_o(q_take), .res_valid_o(res_valid), .res_o(res), .res_take_i(pop)
  );

  assign empty = !res_valid;
  assign kind_o = res.kind;
  assign dest_o = res.dest;
  assign board_type_o = res.board_type;
  assign frame_id_o = res.frame_id;
  assign func_code_o = res.func_code;
  assign payload_len_o = res.payload_len;
  assign lin_channel_o = res.lin_channel;
  assign frame_start_o = res.frame_start;
  assign bad_count_o = res.bad_count;
  assign ack_o = res.ack;
  assign read_data_o = res.read_data;
  assign last_o = res.last;
endmodule

FILE: rtl/lfpd_ram.sv
module lfpd_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: rtl/lfpd_front.sv
module lfpd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  lfpd_pkg::cmd_t cmd_i,
  output logic          q_valid_o,
  output lfpd_pkg::cmd_t q_cmd_o,
  input  logic          q_take_i
);
  lfpd_pkg::cmd_t buf_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic       in_x;

  assign full = (cnt_q == 2'd2);
  assign in_x = push && !full;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      if (in_x) begin
        wr_q <= !wr_q;
      end
      if (q_take_i && q_valid_o) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, in_x} - {1'b0, q_take_i && q_valid_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_x) buf_q[wr_q] <= cmd_i;
  end
endmodule

FILE: rtl/lfpd_back.sv
module lfpd_back #(
  parameter int RingDepth = 512
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           ack_en_i,
  input  logic           q_valid_i,
  input  lfpd_pkg::cmd_t q_cmd_i,
  output logic           q_take_o,
  output logic           res_valid_o,
  output lfpd_pkg::res_t res_o,
  input  logic           res_take_i
);
  localparam int Aw = $clog2(RingDepth);

  typedef enum logic [3:0] {
    SIdle, SRdWait, SRdOut, SScan, SScanW, SLenW, SFld, SFldW, SEmit, SBad
  } state_e;

  state_e     state_q;
  logic [Aw-1:0] head_q, wptr_q, cnt_q, off_q, raddr;
  logic [7:0] tally_q, len_q, fid_q, fc_q, bt_q, lc_q, cr_q;
  logic [2:0] fstep_q;
  logic       any_q;
  logic       ram_we;
  logic [7:0] rdata;
  logic [7:0] rbyte_q;
  lfpd_pkg::res_t res_q, hold_q, frame_desc, out_data;
  logic       rv_q;
  logic       out_free, out_load;
  logic [Aw:0] flen;
  logic [Aw-1:0] flen_w;

  assign flen = (Aw+1)'(len_q) + (Aw+1)'(5);
  assign flen_w = flen[Aw-1:0];
  assign ram_we = (state_q == SIdle) && q_valid_i && !q_cmd_i.op;
  assign q_take_o = (state_q == SIdle) && q_valid_i;
  assign res_valid_o = rv_q;
  assign res_o = res_q;
  assign out_free = !rv_q || res_take_i;

  lfpd_ram #(.Width(8), .Depth(RingDepth)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(wptr_q), .wdata_i(q_cmd_i.rx_byte),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  always_comb begin
    raddr = head_q + off_q;
    if (state_q == SIdle) raddr = Aw'(q_cmd_i.read_addr);
  end

  always_comb begin
    frame_desc = '0;
    frame_desc.kind = lfpd_pkg::KindFrame;
    frame_desc.dest = lfpd_pkg::class_of(bt_q);
    frame_desc.board_type = bt_q;
    frame_desc.frame_id = fid_q;
    frame_desc.func_code = fc_q;
    frame_desc.payload_len = len_q;
    frame_desc.lin_channel = (len_q != 8'd0) ? lc_q : 8'd0;
    frame_desc.frame_start = 9'(head_q);
    frame_desc.bad_count = tally_q;
    frame_desc.ack = ack_en_i;
    frame_desc.last = 1'b0;
    out_load = 1'b0;
    out_data = '0;
    unique case (state_q)
      SRdOut: begin
        out_load = out_free;
        out_data.kind = lfpd_pkg::KindRead;
        out_data.read_data = rbyte_q;
        out_data.last = 1'b1;
      end
      SEmit: begin
        out_load = any_q && out_free;
        out_data = hold_q;
      end
      SBad: begin
        if (any_q) begin
          out_load = out_free;
          out_data = hold_q;
          out_data.last = (tally_q == 8'd0);
        end else if (tally_q != 8'd0) begin
          out_load = out_free;
          out_data.kind = lfpd_pkg::KindBad;
          out_data.bad_count = tally_q;
          out_data.ack = ack_en_i;
          out_data.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      head_q <= '0;
      wptr_q <= '0;
      cnt_q <= '0;
      off_q <= '0;
      tally_q <= '0;
      rv_q <= 1'b0;
      fstep_q <= '0;
      any_q <= 1'b0;
      len_q <= '0; fid_q <= '0; fc_q <= '0; bt_q <= '0; lc_q <= '0; cr_q <= '0;
      rbyte_q <= '0;
      hold_q <= '0;
      res_q <= '0;
    end else begin
      if (out_load) begin
        rv_q <= 1'b1;
        res_q <= out_data;
      end else if (res_take_i) rv_q <= 1'b0;
      unique case (state_q)
        SIdle: if (q_valid_i) begin
          if (q_cmd_i.op) state_q <= SRdWait;
          else begin
            wptr_q <= wptr_q + 1'b1;
            if (cnt_q == Aw'(RingDepth - 1)) head_q <= head_q + 1'b1;
            else cnt_q <= cnt_q + 1'b1;
            off_q <= '0;
            state_q <= SScan;
          end
        end
        SRdWait: begin
          rbyte_q <= rdata;
          state_q <= SRdOut;
        end
        SRdOut: if (out_free) state_q <= SIdle;
        SScan: begin
          if (cnt_q < Aw'(5)) state_q <= SBad;
          else if (off_q == cnt_q) begin
            head_q <= wptr_q; cnt_q <= '0; state_q <= SBad;
          end else state_q <= SScanW;
        end
        SScanW: begin
          if (rdata == lfpd_pkg::HeaderByte) begin
            head_q <= head_q + off_q;
            cnt_q <= cnt_q - off_q;
            if (cnt_q - off_q < Aw'(2)) state_q <= SBad;
            else begin off_q <= Aw'(1); state_q <= SLenW; end
          end else begin
            off_q <= off_q + 1'b1;
            state_q <= SScan;
          end
        end
        SLenW: state_q <= SFld;
        SFld: begin
          if (fstep_q == 3'd0) begin
            len_q <= rdata;
            if ({1'b0, cnt_q} < (Aw+1)'(rdata) + (Aw+1)'(5)) begin
              off_q <= '0; state_q <= SBad;
            end else begin
              off_q <= Aw'(2); fstep_q <= 3'd1; state_q <= SFldW;
            end
          end else begin
            unique case (fstep_q)
              3'd1: fid_q <= rdata;
              3'd2: fc_q <= rdata;
              3'd3: bt_q <= rdata;
              3'd4: lc_q <= rdata;
              3'd5: cr_q <= rdata;
              default: ;
            endcase
            if (fstep_q == 3'd6) begin
              fstep_q <= '0;
              if (cr_q == lfpd_pkg::TrailCr && rdata == lfpd_pkg::TrailLf)
                state_q <= SEmit;
              else begin
                head_q <= head_q + 1'b1; cnt_q <= cnt_q - 1'b1;
                if (tally_q != 8'hFF) tally_q <= tally_q + 1'b1;
                off_q <= '0; state_q <= SScan;
              end
            end else begin
              fstep_q <= fstep_q + 1'b1;
              unique case (fstep_q)
                3'd1: off_q <= Aw'(3);
                3'd2: off_q <= Aw'(4);
                3'd3: off_q <= Aw'(5);
                3'd4: off_q <= flen_w - Aw'(2);
                default: off_q <= flen_w - Aw'(1);
              endcase
              state_q <= SFldW;
            end
          end
        end
        SFldW: state_q <= SFld;
        SEmit: if (!any_q || out_free) begin
          hold_q <= frame_desc;
          any_q <= 1'b1;
          tally_q <= '0;
          head_q <= head_q + flen_w;
          cnt_q <= cnt_q - flen_w;
          off_q <= '0;
          state_q <= SScan;
        end
        SBad: begin
          if (any_q) begin
            if (out_free) begin
              any_q <= 1'b0;
              if (tally_q == 8'd0) state_q <= SIdle;
            end
          end else if (tally_q == 8'd0) state_q <= SIdle;
          else if (out_free) begin
            tally_q <= '0;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

FILE: rtl/lfpd_checker.sv
module lfpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [1:0] kind_o,
  input logic [7:0] bad_count_o,
  input logic       ack_o,
  input logic       last_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(kind_o)) else $error("result dropped");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> kind_o != 2'd3) else $error("bad kind");
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o == 2'd1 |-> bad_count_o != 8'd0 && last_o)
    else $error("empty bad notice");
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o == 2'd2 |-> last_o && !ack_o) else $error("read result");
endmodule

bind length_framed_packet_deframer_unit lfpd_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .kind_o, .bad_count_o, .ack_o, .last_o
);
